// ===== design/momentum_rescale_along_vector_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the momentum rescale unit
// Shared concurrent-assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MOMENTUM_RESCALE_ALONG_VECTOR_UNIT_MACROS_SVH
`define MOMENTUM_RESCALE_ALONG_VECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define MRV_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRV_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mrv_pkg.sv =====
// ----------------------------------------------------------------------------
// mrv_pkg
// Types, constants and Q.32 helper functions of the momentum rescale unit.
// ----------------------------------------------------------------------------
package mrv_pkg;

	localparam logic signed [63:0] INT64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] INT64_MIN   = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] CLAMP62     = 64'sh4000_0000_0000_0000;
	localparam logic signed [63:0] NEG_CLAMP62 = 64'shC000_0000_0000_0000;
	localparam logic [127:0]       ROUND_HALF  = 128'h8000_0000;

	typedef struct packed {
		logic start;
		logic rnd;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_rsp_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		mag64 = x[63] ? (~x + 64'd1) : x;
	endfunction

	function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input logic neg);
		if (neg) begin
			apply_sign = m[63] ? INT64_MIN : signed'(~m + 64'd1);
		end else begin
			apply_sign = m[63] ? INT64_MAX : signed'(m);
		end
	endfunction

	// p holds |x*y| + 2^31; take bits 95:32 with saturation
	function automatic logic signed [63:0] qround(input logic [127:0] p, input logic neg);
		if (|p[127:96]) begin
			qround = neg ? INT64_MIN : INT64_MAX;
		end else begin
			qround = apply_sign(p[95:32], neg);
		end
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(INT64_MAX)) begin
			sat_add = INT64_MAX;
		end else if (s < 65'(INT64_MIN)) begin
			sat_add = INT64_MIN;
		end else begin
			sat_add = s[63:0];
		end
	endfunction

endpackage

// ===== design/mrv_in_if.sv =====
// ----------------------------------------------------------------------------
// mrv_in_if
// Input channel: one degree of freedom per transfer.
// ----------------------------------------------------------------------------
interface mrv_in_if #(
	parameter int VALUE_WIDTH = 48
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] momentum;
	logic        [VALUE_WIDTH-2:0] inverse_mass;
	logic signed [VALUE_WIDTH-1:0] direction;
	logic signed [VALUE_WIDTH-1:0] energy_drop;
	logic                          last_in;

	modport source (output valid, momentum, inverse_mass, direction, energy_drop, last_in,
		input ready);
	modport sink (input valid, momentum, inverse_mass, direction, energy_drop, last_in,
		output ready);
endinterface

// ===== design/mrv_out_if.sv =====
// ----------------------------------------------------------------------------
// mrv_out_if
// Output channel: one rescaled momentum per transfer.
// ----------------------------------------------------------------------------
interface mrv_out_if #(
	parameter int VALUE_WIDTH = 48
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] new_momentum;
	logic                          frustrated;
	logic                          last_out;

	modport source (output valid, new_momentum, frustrated, last_out, input ready);
	modport sink (input valid, new_momentum, frustrated, last_out, output ready);
endinterface

// ===== design/mrv_mul.sv =====
// ----------------------------------------------------------------------------
// mrv_mul
// Shared 64x64 unsigned multiplier built from one 32x32 multiplier over
// four partial products; optional +2^31 rounding offset.
// ----------------------------------------------------------------------------
module mrv_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mrv_pkg::mul_req_t req,
	input  logic [63:0]       a,
	input  logic [63:0]       b,
	output mrv_pkg::mul_rsp_t rsp,
	output logic [127:0]      prod
);
	logic [63:0]  a_q, b_q;
	logic [63:0]  pp_q;
	logic [1:0]   sh_q;
	logic [2:0]   step_q;
	logic         busy_q, done_q;
	logic [127:0] acc_q;
	logic [127:0] pp_shift;
	logic [31:0]  a_half, b_half;

	assign a_half = step_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_half = step_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (sh_q)
			2'd0:    pp_shift = {64'd0, pp_q};
			2'd1:    pp_shift = {32'd0, pp_q, 32'd0};
			2'd2:    pp_shift = {pp_q, 64'd0};
			default: pp_shift = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !req.start && busy_q && (step_q == 3'd4);
			if (req.start) begin
				a_q    <= a;
				b_q    <= b;
				acc_q  <= req.rnd ? mrv_pkg::ROUND_HALF : '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (step_q != 3'd4) begin
					pp_q   <= 64'(a_half) * 64'(b_half);
					sh_q   <= 2'(step_q[1]) + 2'(step_q[0]);
					step_q <= step_q + 3'd1;
				end else begin
					busy_q <= 1'b0;
				end
				if (step_q != 3'd0) begin
					acc_q <= acc_q + pp_shift;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign prod     = acc_q;
endmodule

// ===== design/mrv_sqrt.sv =====
// ----------------------------------------------------------------------------
// mrv_sqrt
// Digit-by-digit truncated square root of a 128-bit value, two radicand
// bits per cycle.
// ----------------------------------------------------------------------------
module mrv_sqrt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] radicand,
	output logic         done,
	output logic [63:0]  root
);
	logic [127:0] rad_q;
	logic [65:0]  rem_q;
	logic [63:0]  root_q;
	logic [5:0]   cnt_q;
	logic         busy_q, done_q;
	logic [67:0]  rem4, trial, rem_diff;
	logic         take;

	assign rem4     = {rem_q, rad_q[127:126]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign take     = rem4 >= trial;
	assign rem_diff = rem4 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 6'd63);
			if (start) begin
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rad_q  <= {rad_q[125:0], 2'b00};
				rem_q  <= take ? rem_diff[65:0] : rem4[65:0];
				root_q <= {root_q[62:0], take};
				cnt_q  <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== design/mrv_div.sv =====
// ----------------------------------------------------------------------------
// mrv_div
// Restoring divider: floor((mag << 32 or 33) / den), one quotient bit per
// cycle, saturated to the signed 64-bit maximum.
// ----------------------------------------------------------------------------
module mrv_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] mag,
	input  logic        sh33,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quot
);
	logic [127:0] dvd_q;
	logic [63:0]  den_q, rem_q, q_q;
	logic         over_q;
	logic [6:0]   cnt_q;
	logic         busy_q, done_q;
	logic [63:0]  rem_sh;
	logic         take;

	assign rem_sh = {rem_q[62:0], dvd_q[127]};
	assign take   = rem_q[63] || (rem_sh >= den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 7'd127);
			if (start) begin
				dvd_q  <= sh33 ? {31'd0, mag, 33'd0} : {32'd0, mag, 32'd0};
				den_q  <= den;
				rem_q  <= '0;
				q_q    <= '0;
				over_q <= 1'b0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				dvd_q  <= {dvd_q[126:0], 1'b0};
				rem_q  <= take ? rem_sh - den_q : rem_sh;
				over_q <= over_q | q_q[63] | q_q[62];
				q_q    <= {q_q[62:0], take};
				cnt_q  <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = (over_q || q_q[63]) ? 64'(mrv_pkg::INT64_MAX) : q_q;
endmodule

// ===== design/momentum_rescale_along_vector_unit.sv =====
// ----------------------------------------------------------------------------
// momentum_rescale_along_vector_unit
// Rescales a set of momenta along a direction vector after a surface hop.
// ----------------------------------------------------------------------------
// One degree of freedom (momentum p, inverse mass m, direction t) is taken
// per transfer; p and t go to on-chip stores, and S = sum(t*t*m) and
// B = sum(p*t*m) are accumulated. The transfer marked last_in also carries the
// energy drop c; the unit then forms D = B*B + 2*S*c, picks gamma (2B/S on a
// frustrated hop with reversal enabled, 0 if not enabled or S is zero,
// otherwise (B -+ sqrt(D))/S) and sends p - gamma*t for every stored element
// in arrival order, last_out on the final one. Elements beyond MAX_DOF are
// dropped; a dropped last element still ends the set. All math is Q.32,
// rounded to nearest and saturated. Timing: the input is not ready while an
// element is worked on. Each element takes three products through the one
// shared 32x32 multiplier (four partial products each), after the idle state
// that takes the transfer. The end of a set forms B*B and S*c, then the
// discriminant, then the square root and the division (the square root is
// skipped on a frustrated hop, both are skipped when gamma is set to zero),
// then one product per emitted element, held up while the output stalls.
// The output register lets a result wait for its consumer while the next
// element is computed. The user must write reverse_on_frustrated through
// cfg_wr_en/cfg_wr_data only while the unit is idle; the unit itself does
// not enforce this.
// ----------------------------------------------------------------------------
module momentum_rescale_along_vector_unit #(
	parameter int MAX_DOF     = 32,
	parameter int VALUE_WIDTH = 48
) (
	input  logic            clk,
	input  logic            arst_n,
	mrv_in_if.sink          in_ch,
	mrv_out_if.source       out_ch,
	input  logic            cfg_wr_en,
	input  logic            cfg_wr_data
);
	`include "momentum_rescale_along_vector_unit_macros.svh"

	localparam int CNT_W = $clog2(MAX_DOF + 1);
	localparam int IDX_W = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;
	localparam logic signed [64:0] VMAX = (65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1;
	localparam logic signed [64:0] VMIN = -VMAX - 65'sd1;

	typedef enum logic [3:0] {
		S_IDLE, S_W, S_X, S_Y, S_BSQ, S_CX, S_DISC, S_SQRT, S_DIV,
		S_ERD, S_EMUL, S_EW, S_EPUT
	} state_t;

	state_t state_q;

	// run state
	logic [CNT_W-1:0]  count_q, emit_idx_q;
	logic signed [63:0] quad_q, cross_q;
	logic               rev_q;

	// current element
	logic signed [63:0] p_q, t_q, c_q, w_q;
	logic               last_q;

	// end-of-set values
	logic [127:0]       bsq_q, xs_q;
	logic               frus_q;
	logic signed [63:0] gamma_q;
	logic               gneg_q;
	logic [VALUE_WIDTH-1:0] res_q;

	// shared units
	mrv_pkg::mul_req_t mul_req_q;
	mrv_pkg::mul_rsp_t mul_rsp;
	logic [63:0]       mul_a_q, mul_b_q;
	logic [127:0]      mul_prod;
	logic              sqrt_start_q, sqrt_done;
	logic [127:0]      rad_q;
	logic [63:0]       sqrt_root;
	logic              div_start_q, div_done, div_sh33_q;
	logic [63:0]       div_mag_q, div_quot;

	// stores
	logic [VALUE_WIDTH-1:0]        mom_mem [MAX_DOF];
	logic [VALUE_WIDTH-1:0]        dir_mem [MAX_DOF];
	logic signed [VALUE_WIDTH-1:0] rd_mom_q, rd_dir_q;
	logic                          wr_en;

	// output register
	logic                   out_valid_q, out_frus_q, out_last_q;
	logic [VALUE_WIDTH-1:0] out_mom_q;

	// combinational helpers
	logic signed [63:0] p_in, t_in, c_in, w_next, cross_next;
	logic               has_room, in_xfer, is_last, out_load;
	logic [127:0]       d_next;
	logic               frus_next;
	logic [63:0]        bm, nm;
	logic               nneg;
	logic signed [63:0] p_k, t_k, d_raw, d_cl;
	logic signed [64:0] diff, diff_sat;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign has_room    = count_q < CNT_W'(MAX_DOF);
	assign wr_en       = in_xfer && has_room;

	assign p_in = 64'(in_ch.momentum);
	assign t_in = 64'(in_ch.direction);
	assign c_in = 64'(in_ch.energy_drop);

	assign w_next     = mrv_pkg::qround(mul_prod, t_q[63]);
	assign cross_next = mrv_pkg::sat_add(cross_q, mrv_pkg::qround(mul_prod, p_q[63] ^ w_q[63]));

	// discriminant D = B*B + 2*S*c, negative means frustrated
	always_comb begin
		frus_next = 1'b0;
		if (!c_q[63]) begin
			d_next = bsq_q + xs_q;
		end else if (xs_q > bsq_q) begin
			frus_next = 1'b1;
			d_next    = '0;
		end else begin
			d_next = bsq_q - xs_q;
		end
	end

	// numerator B -+ sqrt(D), with the sqrt term opposite in sign to B
	assign bm   = mrv_pkg::mag64(cross_q);
	assign nneg = cross_q[63] ? (sqrt_root < bm) : (bm < sqrt_root);
	assign nm   = (sqrt_root < bm) ? (bm - sqrt_root) : (sqrt_root - bm);

	// emit arithmetic: p - clamp(gamma*t), saturated to the value range
	assign p_k = 64'(rd_mom_q);
	assign t_k = 64'(rd_dir_q);
	always_comb begin
		d_raw = mrv_pkg::qround(mul_prod, gamma_q[63] ^ t_k[63]);
		d_cl  = d_raw;
		if (d_raw > mrv_pkg::CLAMP62) begin
			d_cl = mrv_pkg::CLAMP62;
		end else if (d_raw < mrv_pkg::NEG_CLAMP62) begin
			d_cl = mrv_pkg::NEG_CLAMP62;
		end
		diff     = 65'(p_k) - 65'(d_cl);
		diff_sat = diff;
		if (diff > VMAX) begin
			diff_sat = VMAX;
		end else if (diff < VMIN) begin
			diff_sat = VMIN;
		end
	end

	assign is_last  = (emit_idx_q == count_q - CNT_W'(1));
	assign out_load = (state_q == S_EPUT) && (!out_valid_q || out_ch.ready);

	// element stores, registered read at the emit index
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mom_mem[count_q[IDX_W-1:0]] <= in_ch.momentum;
			dir_mem[count_q[IDX_W-1:0]] <= in_ch.direction;
		end
		rd_mom_q <= mom_mem[emit_idx_q[IDX_W-1:0]];
		rd_dir_q <= dir_mem[emit_idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			emit_idx_q   <= '0;
			quad_q       <= '0;
			cross_q      <= '0;
			rev_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			mul_req_q    <= '0;
			sqrt_start_q <= 1'b0;
			div_start_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				rev_q <= cfg_wr_data;
			end
			// output register: loaded from S_EPUT, freed by the consumer
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						p_q    <= p_in;
						t_q    <= t_in;
						c_q    <= c_in;
						last_q <= in_ch.last_in;
						if (has_room) begin
							mul_a_q   <= mrv_pkg::mag64(t_in);
							mul_b_q   <= 64'(in_ch.inverse_mass);
							mul_req_q <= '{start: 1'b1, rnd: 1'b1};
							state_q   <= S_W;
						end else if (in_ch.last_in) begin
							mul_a_q   <= bm;
							mul_b_q   <= bm;
							mul_req_q <= '{start: 1'b1, rnd: 1'b0};
							state_q   <= S_BSQ;
						end
					end
				end
				S_W: begin
					if (mul_rsp.done) begin
						w_q       <= w_next;
						mul_a_q   <= mrv_pkg::mag64(t_q);
						mul_b_q   <= mrv_pkg::mag64(w_next);
						mul_req_q <= '{start: 1'b1, rnd: 1'b1};
						state_q   <= S_X;
					end else begin
						mul_req_q.start <= 1'b0;
					end
				end
				S_X: begin
					if (mul_rsp.done) begin
						quad_q    <= mrv_pkg::sat_add(quad_q,
							mrv_pkg::qround(mul_prod, t_q[63] ^ w_q[63]));
						mul_a_q   <= mrv_pkg::mag64(p_q);
						mul_b_q   <= mrv_pkg::mag64(w_q);
						mul_req_q <= '{start: 1'b1, rnd: 1'b1};
						state_q   <= S_Y;
					end else begin
						mul_req_q.start <= 1'b0;
					end
				end
				S_Y: begin
					if (mul_rsp.done) begin
						cross_q <= cross_next;
						count_q <= count_q + CNT_W'(1);
						if (last_q) begin
							mul_a_q   <= mrv_pkg::mag64(cross_next);
							mul_b_q   <= mrv_pkg::mag64(cross_next);
							mul_req_q <= '{start: 1'b1, rnd: 1'b0};
							state_q   <= S_BSQ;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						mul_req_q.start <= 1'b0;
					end
				end
				S_BSQ: begin
					if (mul_rsp.done) begin
						bsq_q     <= mul_prod;
						mul_a_q   <= quad_q;
						mul_b_q   <= mrv_pkg::mag64(c_q);
						mul_req_q <= '{start: 1'b1, rnd: 1'b0};
						state_q   <= S_CX;
					end else begin
						mul_req_q.start <= 1'b0;
					end
				end
				S_CX: begin
					if (mul_rsp.done) begin
						xs_q    <= {mul_prod[126:0], 1'b0};
						state_q <= S_DISC;
					end else begin
						mul_req_q.start <= 1'b0;
					end
				end
				S_DISC: begin
					frus_q     <= frus_next;
					emit_idx_q <= '0;
					if (quad_q == 64'sd0) begin
						gamma_q <= '0;
						state_q <= S_ERD;
					end else if (frus_next) begin
						if (rev_q) begin
							div_mag_q   <= bm;
							div_sh33_q  <= 1'b1;
							gneg_q      <= cross_q[63];
							div_start_q <= 1'b1;
							state_q     <= S_DIV;
						end else begin
							gamma_q <= '0;
							state_q <= S_ERD;
						end
					end else begin
						rad_q        <= d_next;
						sqrt_start_q <= 1'b1;
						state_q      <= S_SQRT;
					end
				end
				S_SQRT: begin
					sqrt_start_q <= 1'b0;
					if (sqrt_done) begin
						div_mag_q   <= nm;
						div_sh33_q  <= 1'b0;
						gneg_q      <= nneg;
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					div_start_q <= 1'b0;
					if (div_done) begin
						gamma_q <= mrv_pkg::apply_sign(div_quot, gneg_q);
						state_q <= S_ERD;
					end
				end
				S_ERD: begin
					state_q <= S_EMUL;
				end
				S_EMUL: begin
					mul_a_q   <= mrv_pkg::mag64(gamma_q);
					mul_b_q   <= mrv_pkg::mag64(t_k);
					mul_req_q <= '{start: 1'b1, rnd: 1'b1};
					state_q   <= S_EW;
				end
				S_EW: begin
					if (mul_rsp.done) begin
						res_q   <= diff_sat[VALUE_WIDTH-1:0];
						state_q <= S_EPUT;
					end else begin
						mul_req_q.start <= 1'b0;
					end
				end
				S_EPUT: begin
					if (out_load) begin
						out_mom_q   <= res_q;
						out_frus_q  <= frus_q;
						out_last_q  <= is_last;
						if (is_last) begin
							quad_q  <= '0;
							cross_q <= '0;
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + CNT_W'(1);
							state_q    <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	mrv_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.rsp    (mul_rsp),
		.prod   (mul_prod)
	);

	mrv_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start_q),
		.radicand (rad_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	mrv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.mag    (div_mag_q),
		.sh33   (div_sh33_q),
		.den    (quad_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign out_ch.valid        = out_valid_q;
	assign out_ch.new_momentum = out_mom_q;
	assign out_ch.frustrated   = out_frus_q;
	assign out_ch.last_out     = out_last_q;

	`MRV_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_DOF), "element count past depth")
	`MRV_ASSERT_IMP(a_mul_no_overlap, mul_req_q.start, !mul_rsp.busy, "multiplier restarted busy")
	`MRV_ASSERT_IMP(a_run_open, out_valid_q && !out_last_q, state_q != S_IDLE, "run closed early")
	`MRV_ASSERT_NXT(a_clear_after_last, out_load && is_last, state_q == S_IDLE && count_q == '0,
		"set not cleared after last element")
endmodule

// ===== tb/mrv_checker.sv =====
// ----------------------------------------------------------------------------
// mrv_checker
// Watches both channels and the config port, predicts the rescaled momenta
// of every set in Q.32 and compares each output transfer with the oldest one.
// ----------------------------------------------------------------------------
module mrv_checker #(
	parameter int MAX_DOF     = 32,
	parameter int VALUE_WIDTH = 48
) (
	input  logic clk,
	input  logic arst_n,
	mrv_in_if    in_ch,
	mrv_out_if   out_ch,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	output int   errors,
	output int   pending,
	output int   results,
	output int   frus_sets
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (VALUE_WIDTH - 1));

	typedef struct {
		logic signed [VALUE_WIDTH-1:0] mom;
		logic                          frus;
		logic                          last;
	} rescaled_t;

	rescaled_t               rescaled_q[$];
	logic signed [63:0]      mom_buf[MAX_DOF];
	logic signed [63:0]      dir_buf[MAX_DOF];
	logic signed [63:0]      quad_acc;
	logic signed [63:0]      cross_acc;
	int                      dof_count;
	logic                    reverse_en;

	function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
		if (neg) begin
			return m[63] ? mrv_pkg::INT64_MIN : -$signed(m);
		end else begin
			return m[63] ? mrv_pkg::INT64_MAX : $signed(m);
		end
	endfunction

	function automatic logic [63:0] abs64(input logic signed [63:0] x);
		return x[63] ? 64'(-x) : 64'(x);
	endfunction

	// rounded, saturated Q.32 product
	function automatic logic signed [63:0] q32_mul(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic [127:0] pr;
		logic         neg;
		neg = x[63] ^ y[63];
		pr = {64'd0, abs64(x)} * {64'd0, abs64(y)} + 128'h8000_0000;
		if (|pr[127:96]) return neg ? mrv_pkg::INT64_MIN : mrv_pkg::INT64_MAX;
		return from_mag(pr[95:32], neg);
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(mrv_pkg::INT64_MAX)) return mrv_pkg::INT64_MAX;
		if (s < 65'(mrv_pkg::INT64_MIN)) return mrv_pkg::INT64_MIN;
		return s[63:0];
	endfunction

	function automatic logic [63:0] scaled_quot(input logic [63:0] mag, input int sh,
			input logic [63:0] den);
		logic [127:0] q;
		q = ({64'd0, mag} << sh) / {64'd0, den};
		return (q > 128'(mrv_pkg::INT64_MAX)) ? 64'(mrv_pkg::INT64_MAX) : q[63:0];
	endfunction

	function automatic logic [63:0] root128(input logic [127:0] d);
		logic [63:0] r;
		logic [63:0] cand;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= d) r = cand;
		end
		return r;
	endfunction

	// closes a set: works out gamma and queues one rescaled momentum per element
	task automatic rescale_set(input logic signed [63:0] drop);
		logic [63:0]        bm, nm, rt;
		logic [127:0]       bb, xx, disc;
		logic signed [63:0] gamma, d, r;
		logic               frus, nneg;
		rescaled_t          e;
		bm = abs64(cross_acc);
		bb = {64'd0, bm} * {64'd0, bm};
		xx = ({64'd0, quad_acc} * {64'd0, abs64(drop)}) << 1;
		frus = 0;
		gamma = 0;
		disc = 0;
		if (!drop[63]) disc = bb + xx;
		else if (xx > bb) frus = 1;
		else disc = bb - xx;
		if (quad_acc != 0) begin
			if (frus) begin
				if (reverse_en) gamma = from_mag(scaled_quot(bm, 33, quad_acc), cross_acc[63]);
			end else begin
				rt = root128(disc);
				if (cross_acc[63]) begin
					nneg = rt < bm;
					nm = nneg ? bm - rt : rt - bm;
				end else begin
					nneg = bm < rt;
					nm = nneg ? rt - bm : bm - rt;
				end
				gamma = from_mag(scaled_quot(nm, 32, quad_acc), nneg);
			end
		end
		if (frus) frus_sets++;
		for (int k = 0; k < dof_count; k++) begin
			d = q32_mul(gamma, dir_buf[k]);
			if (d > mrv_pkg::CLAMP62) d = mrv_pkg::CLAMP62;
			if (d < mrv_pkg::NEG_CLAMP62) d = mrv_pkg::NEG_CLAMP62;
			r = mom_buf[k] - d;
			if (r > OUT_MAX) r = OUT_MAX;
			if (r < OUT_MIN) r = OUT_MIN;
			e.mom = r[VALUE_WIDTH-1:0];
			e.frus = frus;
			e.last = (k == dof_count - 1);
			rescaled_q.insert(rescaled_q.size(), e);
		end
		quad_acc = 0;
		cross_acc = 0;
		dof_count = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [63:0] p, m, t, w;
		rescaled_t          want;
		if (!arst_n) begin
			quad_acc = 0;
			cross_acc = 0;
			dof_count = 0;
			reverse_en = 0;
			errors = 0;
			results = 0;
			frus_sets = 0;
			rescaled_q.delete();
		end else begin
			if (cfg_wr_en) reverse_en = cfg_wr_data;
			if (out_ch.valid && out_ch.ready) begin
				results++;
				if (rescaled_q.size() == 0) begin
					$error("unexpected output transfer, new_momentum %0d", out_ch.new_momentum);
					errors++;
				end else begin
					want = rescaled_q.pop_front();
					if (out_ch.new_momentum !== want.mom) begin
						$error("new_momentum expected %0d got %0d", want.mom, out_ch.new_momentum);
						errors++;
					end
					if (out_ch.frustrated !== want.frus) begin
						$error("frustrated expected %0b got %0b", want.frus, out_ch.frustrated);
						errors++;
					end
					if (out_ch.last_out !== want.last) begin
						$error("last_out expected %0b got %0b", want.last, out_ch.last_out);
						errors++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				p = 64'(in_ch.momentum);
				m = 64'(in_ch.inverse_mass);
				t = 64'(in_ch.direction);
				if (dof_count < MAX_DOF) begin
					w = q32_mul(t, m);
					mom_buf[dof_count] = p;
					dir_buf[dof_count] = t;
					quad_acc = add_sat(quad_acc, q32_mul(t, w));
					cross_acc = add_sat(cross_acc, q32_mul(p, w));
					dof_count++;
				end
				if (in_ch.last_in) rescale_set(64'(in_ch.energy_drop));
			end
		end
		pending = rescaled_q.size();
	end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives sets of degrees of freedom into the rescale unit with random gaps
// and output stalls, flips the reversal setting between phases and reports
// the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DOF     = 32;
	localparam int VALUE_WIDTH = 48;
	localparam int LIMIT       = 600000;
	localparam logic signed [47:0] ONE  = 48'sh1_0000_0000;   // 1.0 in Q.32
	localparam logic signed [47:0] VMAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] VMIN = 48'sh8000_0000_0000;
	localparam logic [46:0]        MMAX = 47'h7FFF_FFFF_FFFF;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;
	int   errors, pending, results, frus_sets;
	int   items_sent;
	bit   idle_on;       // random bursts on both sides
	bit   long_hold;     // one long output stall request

	mrv_in_if  #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
	mrv_out_if #(.VALUE_WIDTH(VALUE_WIDTH)) out_ch ();

	momentum_rescale_along_vector_unit #(
		.MAX_DOF(MAX_DOF),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	mrv_checker #(
		.MAX_DOF(MAX_DOF),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.errors(errors),
		.pending(pending),
		.results(results),
		.frus_sets(frus_sets)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog: sized from the slowest legal run, many times over
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: ready changes on falling edges only
	initial begin
		out_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				// long stall, counted here, so the unit backs up into its input
				out_ch.ready <= 0;
				repeat (400) @(negedge clk);
				long_hold = 0;
				out_ch.ready <= 1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 0;
				repeat ($urandom_range(1, 5) - 1) @(negedge clk);
			end else begin
				out_ch.ready <= 1;
			end
		end
	end

	// one input transfer; called on a falling edge, returns on a falling edge
	// with valid still up, so the next call or drain decides what follows
	task automatic send_dof(input logic signed [47:0] p, input logic [46:0] m,
			input logic signed [47:0] t, input logic signed [47:0] c, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.momentum <= p;
		in_ch.inverse_mass <= m;
		in_ch.direction <= t;
		in_ch.energy_drop <= c;
		in_ch.last_in <= last;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// waits out all expected results plus the tail of the unit's work
	task automatic drain;
		in_ch.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reverse(input logic v);
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	// signed Q.32 value: mostly moderate, sometimes full range, an extreme or zero
	function automatic logic signed [47:0] rand_q();
		logic signed [47:0] v;
		case ($urandom_range(0, 9))
			0: v = 48'({$urandom, $urandom});
			1: v = $urandom_range(0, 1) ? VMAX : VMIN;
			2: v = '0;
			default: begin
				v = 48'(signed'($urandom));
				v = v <<< $urandom_range(0, 7);
			end
		endcase
		return v;
	endfunction

	function automatic logic [46:0] rand_mass();
		case ($urandom_range(0, 9))
			0: return 47'({$urandom, $urandom});
			1: return $urandom_range(0, 1) ? MMAX : 47'd0;
			default: return 47'(ONE) + 47'($urandom_range(0, 32'hFFFF_FFFF)) *
				47'($urandom_range(0, 3));
		endcase
	endfunction

	// directed sets: accepted hops either sign of b, frustrated hop, zero S, extremes
	task automatic directed_sets;
		send_dof(ONE, 47'(ONE), ONE, ONE, 1'b1);
		send_dof(-2 * ONE, 47'(ONE), ONE, ONE / 2, 1'b1);
		send_dof(ONE / 4, 47'(ONE), ONE, -10 * ONE, 1'b1);
		send_dof(-ONE / 4, 47'(ONE), ONE, -10 * ONE, 1'b1);
		send_dof(3 * ONE, 47'd0, ONE, ONE, 1'b1);
		send_dof(VMAX, MMAX, VMAX, VMAX, 1'b1);
		send_dof(VMIN, MMAX, VMIN, VMIN, 1'b1);
		send_dof('0, 47'(ONE), '0, '0, 1'b0);
		send_dof(ONE, 47'(ONE), -ONE, '0, 1'b1);
		send_dof(ONE, 47'(ONE), ONE, VMIN, 1'b0);
		send_dof(-ONE, 47'(2 * ONE), ONE / 2, VMAX, 1'b1);
	endtask

	// random set: mostly short, now and then near or past the buffer size
	task automatic random_set;
		int n;
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(MAX_DOF - 2, MAX_DOF + 3)
			: $urandom_range(1, 6);
		for (int k = 0; k < n; k++) begin
			send_dof(rand_q(), rand_mass(), rand_q(), rand_q(), k == n - 1);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		idle_on = 0;
		long_hold = 0;
		items_sent = 0;
		in_ch.valid = 0;
		in_ch.momentum = 0;
		in_ch.inverse_mass = 0;
		in_ch.direction = 0;
		in_ch.energy_drop = 0;
		in_ch.last_in = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed, reversal off then on, no idling
		write_reverse(1'b0);
		directed_sets();
		drain();
		write_reverse(1'b1);
		directed_sets();
		drain();

		// random phases with idling, alternating the reversal setting
		idle_on = 1;
		for (int ph = 0; ph < 4; ph++) begin
			write_reverse(ph[0]);
			if (ph == 1) long_hold = 1;
			while (items_sent < 50 + (ph + 1) * 60) random_set();
			drain();
		end

		// closing stretch without idling
		idle_on = 0;
		write_reverse(1'b0);
		while (items_sent < 320) random_set();
		drain();

		$display("Ran %0d input transfers into %0d checked results, %0d frustrated sets,",
			items_sent, results, frus_sets);
		$display("with reversal on and off, output stalls and buffer-overflow sets.");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
